// ===== hdl/tdcdefr_pkg.sv =====
package tdcdefr_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CHANNEL_W  = 7;
    localparam int unsigned TIME_W     = 20;
    localparam int unsigned EVENT_W    = 12;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned TYPE_W     = 2;

    localparam int unsigned TYPE_LSB    = 21;
    localparam int unsigned CHANNEL_LSB = 24;

    localparam logic [TYPE_W-1:0] TYPE_HIT    = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_END    = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_HEADER = 2'd2;

    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HIT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HDR_EXPECTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd4;

    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 16'd1024;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [WORD_W-1:0]    hit_word;
        logic [CHANNEL_W-1:0] channel;
        logic [TIME_W-1:0]    hit_time;
        logic [EVENT_W-1:0]   event_number;
        logic [COUNT_W-1:0]   hit_count;
        logic [STATUS_W-1:0]  status;
    } result_t;

endpackage

// ===== hdl/tdcdefr_core.sv =====
module tdcdefr_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [tdcdefr_pkg::WORD_W-1:0]      word,
    input  logic                                advance,
    input  logic [tdcdefr_pkg::COUNT_W-1:0]     hit_capacity,
    output tdcdefr_pkg::result_t                result
);

    logic                               in_block_reg;
    logic                               in_block_next;
    logic [tdcdefr_pkg::COUNT_W-1:0]    block_hits_reg;
    logic [tdcdefr_pkg::COUNT_W-1:0]    block_hits_next;
    logic [tdcdefr_pkg::EVENT_W-1:0]    block_event_reg;
    logic [tdcdefr_pkg::EVENT_W-1:0]    block_event_next;
    logic [tdcdefr_pkg::TYPE_W-1:0]     word_type;

    assign word_type = word[tdcdefr_pkg::TYPE_LSB +: tdcdefr_pkg::TYPE_W];

    always_comb begin
        in_block_next    = in_block_reg;
        block_hits_next  = block_hits_reg;
        block_event_next = block_event_reg;
        result           = '0;
        result.kind      = tdcdefr_pkg::KIND_ERROR;
        result.status    = tdcdefr_pkg::ST_OK;

        if (!in_block_reg) begin
            if (word_type == tdcdefr_pkg::TYPE_HEADER) begin
                block_event_next = word[tdcdefr_pkg::EVENT_W-1:0];
                block_hits_next  = '0;
                in_block_next    = 1'b1;
                result.kind      = tdcdefr_pkg::KIND_HEADER;
            end else begin
                result.status = tdcdefr_pkg::ST_HDR_EXPECTED;
            end
        end else begin
            case (word_type)
                tdcdefr_pkg::TYPE_HIT: begin
                    if (block_hits_reg >= hit_capacity) begin
                        result.status = tdcdefr_pkg::ST_FULL;
                    end else begin
                        result.kind     = tdcdefr_pkg::KIND_HIT;
                        result.hit_word = word;
                        result.channel  =
                            word[tdcdefr_pkg::CHANNEL_LSB +: tdcdefr_pkg::CHANNEL_W];
                        result.hit_time = word[tdcdefr_pkg::TIME_W-1:0];
                        block_hits_next = block_hits_reg + 1'b1;
                    end
                end
                tdcdefr_pkg::TYPE_END: begin
                    result.kind = tdcdefr_pkg::KIND_END;
                    if (word[tdcdefr_pkg::COUNT_W-1:0] != block_hits_reg) begin
                        result.status = tdcdefr_pkg::ST_MISMATCH;
                    end
                    in_block_next = 1'b0;
                end
                default: begin
                    result.status = tdcdefr_pkg::ST_INVALID;
                end
            endcase
        end

        result.event_number = block_event_next;
        result.hit_count    = block_hits_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_block_reg    <= 1'b0;
            block_hits_reg  <= '0;
            block_event_reg <= '0;
        end else if (advance) begin
            in_block_reg    <= in_block_next;
            block_hits_reg  <= block_hits_next;
            block_event_reg <= block_event_next;
        end
    end

endmodule

// ===== hdl/tdc_event_block_deframer.sv =====
// event block deframer for a time-to-digital converter output buffer
// s_ channel: one raw 32-bit buffer word per item (s_valid / s_ready)
// m_ channel: exactly one result item per input word (m_valid / m_ready),
//   carrying kind, forwarded hit fields, event number, hit count, status
// cfg channel: cfg_data writes hit_capacity (cfg_valid / cfg_ready);
//   cfg_ready is always high, write only while no word is in flight
// pipeline: a word accepted into the input register is decoded by combinational logic
//   and captured in the result register, which drives the m_ ports
// throughput: one word per cycle while the receiver does not stall, set by the input
//   register feeding the decode logic and the result register
// when the receiver stalls the result register holds, the input register
//   still takes one more word if it is empty, then s_ready drops until m_ready returns
// reset (aresetn low, synchronous): both registers empty, no block open,
//   hit count and event number zero, hit_capacity back to 1024
module tdc_event_block_deframer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tdcdefr_pkg::WORD_W-1:0]      s_word,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tdcdefr_pkg::KIND_W-1:0]      m_kind,
    output logic [tdcdefr_pkg::WORD_W-1:0]      m_hit_word,
    output logic [tdcdefr_pkg::CHANNEL_W-1:0]   m_channel,
    output logic [tdcdefr_pkg::TIME_W-1:0]      m_hit_time,
    output logic [tdcdefr_pkg::EVENT_W-1:0]     m_event_number,
    output logic [tdcdefr_pkg::COUNT_W-1:0]     m_hit_count,
    output logic [tdcdefr_pkg::STATUS_W-1:0]    m_status,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tdcdefr_pkg::COUNT_W-1:0]     cfg_data
);

    logic                               in_valid_reg;
    logic [tdcdefr_pkg::WORD_W-1:0]     in_word_reg;
    logic                               out_valid_reg;
    tdcdefr_pkg::result_t               out_result_reg;
    tdcdefr_pkg::result_t               result_next;
    logic [tdcdefr_pkg::COUNT_W-1:0]    capacity_reg;
    logic                               advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    tdcdefr_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .word         (in_word_reg),
        .advance      (advance),
        .hit_capacity (capacity_reg),
        .result       (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= tdcdefr_pkg::CAPACITY_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_word;
        end
        if (advance) begin
            out_result_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_result_reg.kind;
    assign m_hit_word     = out_result_reg.hit_word;
    assign m_channel      = out_result_reg.channel;
    assign m_hit_time     = out_result_reg.hit_time;
    assign m_event_number = out_result_reg.event_number;
    assign m_hit_count    = out_result_reg.hit_count;
    assign m_status       = out_result_reg.status;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tdcdefr_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [TYPE_W-1:0] TYPE_SPARE = 2'd3;

    localparam int FIX_NONE  = 0;
    localparam int FIX_EXACT = 1;
    localparam int FIX_OFF   = 2;

    class event_block_tracker;
        logic [COUNT_W-1:0] capacity;
        bit                 in_block;
        logic [COUNT_W-1:0] block_hits;
        logic [EVENT_W-1:0] block_event;
        result_t            results_due[$];
        int                 errors;

        function new();
            capacity    = CAPACITY_RESET;
            in_block    = 1'b0;
            block_hits  = '0;
            block_event = '0;
            errors      = 0;
        endfunction

        function void set_capacity(logic [COUNT_W-1:0] v);
            capacity = v;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function void note_word(logic [WORD_W-1:0] w);
            result_t         r;
            logic [TYPE_W-1:0] t;
            r        = '0;
            r.kind   = KIND_ERROR;
            r.status = ST_OK;
            t        = w[TYPE_LSB +: TYPE_W];
            if (!in_block) begin
                if (t == TYPE_HEADER) begin
                    block_event = w[EVENT_W-1:0];
                    block_hits  = '0;
                    in_block    = 1'b1;
                    r.kind      = KIND_HEADER;
                end else begin
                    r.status = ST_HDR_EXPECTED;
                end
            end else if (t == TYPE_HIT) begin
                if (block_hits >= capacity) begin
                    r.status = ST_FULL;
                end else begin
                    r.kind     = KIND_HIT;
                    r.hit_word = w;
                    r.channel  = w[CHANNEL_LSB +: CHANNEL_W];
                    r.hit_time = w[TIME_W-1:0];
                    block_hits = block_hits + 1'b1;
                end
            end else if (t == TYPE_END) begin
                r.kind = KIND_END;
                if (w[COUNT_W-1:0] != block_hits) begin
                    r.status = ST_MISMATCH;
                end
                in_block = 1'b0;
            end else begin
                r.status = ST_INVALID;
            end
            r.event_number = block_event;
            r.hit_count    = block_hits;
            results_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] e, logic [WORD_W-1:0] a);
            if (e !== a) begin
                errors++;
                if (errors <= 50) begin
                    $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
                end
            end
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (results_due.size() == 0) begin
                errors++;
                if (errors <= 50) begin
                    $display("%0t: unexpected result item, expected none actual %h",
                             $time, got);
                end
                return;
            end
            exp = results_due.pop_front();
            compare_field("kind", exp.kind, got.kind);
            compare_field("hit_word", exp.hit_word, got.hit_word);
            compare_field("channel", exp.channel, got.channel);
            compare_field("hit_time", exp.hit_time, got.hit_time);
            compare_field("event_number", exp.event_number, got.event_number);
            compare_field("hit_count", exp.hit_count, got.hit_count);
            compare_field("status", exp.status, got.status);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [WORD_W-1:0]     s_word;
    logic                  m_valid;
    logic                  m_ready;
    logic [KIND_W-1:0]     m_kind;
    logic [WORD_W-1:0]     m_hit_word;
    logic [CHANNEL_W-1:0]  m_channel;
    logic [TIME_W-1:0]     m_hit_time;
    logic [EVENT_W-1:0]    m_event_number;
    logic [COUNT_W-1:0]    m_hit_count;
    logic [STATUS_W-1:0]   m_status;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [COUNT_W-1:0]    cfg_data;

    event_block_tracker tracker;
    int                 items_sent;
    int                 cycles;
    bit                 tx_calm;
    bit                 rx_calm;
    bit                 rx_hold_req;
    int                 rx_stall_left;
    result_t            got;

    tdc_event_block_deframer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_word         (s_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_hit_word     (m_hit_word),
        .m_channel      (m_channel),
        .m_hit_time     (m_hit_time),
        .m_event_number (m_event_number),
        .m_hit_count    (m_hit_count),
        .m_status       (m_status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // handshake monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                tracker.set_capacity(cfg_data);
            end
            if (s_valid && s_ready) begin
                tracker.note_word(s_word);
            end
            if (m_valid && m_ready) begin
                got = {m_kind, m_hit_word, m_channel, m_hit_time,
                       m_event_number, m_hit_count, m_status};
                tracker.check_result(got);
            end
        end
    end

    // result receiver with random and forced stalls
    initial begin
        m_ready       = 1'b0;
        rx_stall_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req   = 1'b0;
                rx_stall_left = 300;
            end
            if (rx_stall_left > 0) begin
                m_ready <= 1'b0;
                rx_stall_left--;
            end else if (rx_calm || $urandom_range(0, 99) < 60) begin
                m_ready <= 1'b1;
            end else begin
                rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40)
                                                             : $urandom_range(1, 3);
                m_ready <= 1'b0;
                rx_stall_left--;
            end
        end
    end

    function automatic logic [WORD_W-1:0] random_word(logic [TYPE_W-1:0] t);
        logic [WORD_W-1:0] w;
        w = $urandom;
        w[TYPE_LSB +: TYPE_W] = t;
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    task automatic send(input logic [WORD_W-1:0] w, input int fix);
        int gap;
        @(negedge aclk);
        if (fix == FIX_EXACT) begin
            w[COUNT_W-1:0] = tracker.block_hits;
        end else if (fix == FIX_OFF) begin
            w[COUNT_W-1:0] = tracker.block_hits + COUNT_W'($urandom_range(1, 65535));
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [COUNT_W-1:0] v);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed blocks, some noise and broken sequences
    task automatic run_blocks(input int n_items, input int max_hits);
        int stop_at;
        int nh;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 85) begin
                send(random_word(TYPE_HEADER), FIX_NONE);
                nh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, max_hits)
                                                 : $urandom_range(0, 5);
                repeat (nh) begin
                    if ($urandom_range(0, 24) == 0) begin
                        send(random_word($urandom_range(0, 1) ? TYPE_HEADER : TYPE_SPARE),
                             FIX_NONE);
                    end
                    send(random_word(TYPE_HIT), FIX_NONE);
                end
                send(random_word(TYPE_END), ($urandom_range(0, 6) == 0) ? FIX_OFF : FIX_EXACT);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send(random_word(TYPE_W'($urandom_range(0, 3))), FIX_NONE);
                end
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_word      = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        rx_hold_req = 1'b0;
        items_sent  = 0;
        cycles      = 0;
        tracker     = new();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // words outside a block, then extremes inside one
        send(32'h0000_0000, FIX_NONE);
        send(32'hFFFF_FFFF, FIX_NONE);
        send(32'h0020_0000, FIX_NONE);
        send(32'hFFDF_FFFF, FIX_NONE);
        send(32'h0040_0000, FIX_NONE);
        send(32'h0060_0000, FIX_NONE);
        send(32'hFF9F_FFFF, FIX_NONE);
        send(32'h0000_0000, FIX_NONE);
        send(32'h0020_0002, FIX_NONE);
        send(32'h0040_0000, FIX_NONE);
        send(32'h0020_FFFF, FIX_NONE);

        // zero capacity: every hit is full
        write_capacity(16'd0);
        send(32'h0040_0ABC, FIX_NONE);
        send(random_word(TYPE_HIT), FIX_NONE);
        send(random_word(TYPE_HIT), FIX_NONE);
        send(32'h0020_0000, FIX_NONE);

        // capacity one: second hit is full
        write_capacity(16'd1);
        send(random_word(TYPE_HEADER), FIX_NONE);
        send(random_word(TYPE_HIT), FIX_NONE);
        send(random_word(TYPE_HIT), FIX_NONE);
        send(32'h0020_0001, FIX_NONE);
        send(32'h0020_0001, FIX_NONE);

        write_capacity(16'hFFFF);
        run_blocks(350, 40);

        write_capacity(16'd3);
        run_blocks(300, 8);

        tx_calm = 1'b1;
        rx_calm = 1'b1;
        run_blocks(150, 20);
        rx_calm = 1'b0;

        // receiver holds off while the sender keeps offering
        rx_hold_req = 1'b1;
        run_blocks(120, 12);
        tx_calm = 1'b0;

        write_capacity(CAPACITY_RESET);
        run_blocks(150, 30);
        drain();
        run_blocks(150, 30);

        write_capacity(16'd0);
        run_blocks(150, 4);

        write_capacity(16'd20);
        run_blocks(300, 30);

        write_capacity(16'd1);
        run_blocks(230, 5);

        drain();
        repeat (10) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== tdc_event_block_deframer.f =====
hdl/tdcdefr_pkg.sv
hdl/tdcdefr_core.sv
hdl/tdc_event_block_deframer.sv
tb/sv/testbench.sv
